// ----- hdl/escaped_frame_deframer_assert.svh -----
// Assertion macros used by efd_checker.sv.
`ifndef ESCAPED_FRAME_DEFRAMER_ASSERT_SVH
`define ESCAPED_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define EFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define EFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/efd_pkg.sv -----
`default_nettype none
package efd_pkg;

  localparam int MAX_PAYLOAD_DEF = 64;
  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 7;
  localparam int POS_W           = 6;
  localparam int CFG_IDX_W       = 2;

  localparam logic [BYTE_W-1:0] START_RST  = 8'd0;
  localparam logic [BYTE_W-1:0] END_RST    = 8'd1;
  localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'd2;
  localparam logic [LEN_W-1:0]  MAXLEN_RST = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START  = 2'd0,
    CFG_END    = 2'd1,
    CFG_ESCAPE = 2'd2,
    CFG_MAXLEN = 2'd3
  } cfg_idx_t;

  // One completed frame waiting in a buffer bank
  typedef struct packed {
    logic [BYTE_W-1:0] kind;
    logic [LEN_W-1:0]  len;
    logic              bank;
  } desc_t;

  // One result item
  typedef struct packed {
    logic [BYTE_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
    logic              last;
  } res_t;

endpackage
`default_nettype wire

// ----- hdl/efd_ram.sv -----
`default_nettype none
module efd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/efd_desc_q.sv -----
`default_nettype none
module efd_desc_q
  import efd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire desc_t din,
  input  wire logic  pop,
  output desc_t      dout,
  output logic       empty,
  output logic       full
);

  desc_t       slot_r [2];
  logic        wptr_r;
  logic        rptr_r;
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign dout  = slot_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/efd_front.sv -----
`default_nettype none
module efd_front
  import efd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int IW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_wdata,
  input  wire logic                 in_push,
  input  wire logic [BYTE_W-1:0]    in_rx_data,
  input  wire logic                 dq_full,
  output logic                      ram_we,
  output logic      [IW:0]          ram_waddr,
  output logic      [BYTE_W-1:0]    ram_wdata,
  output logic                      dq_push,
  output desc_t                     dq_din
);

  typedef enum logic [1:0] {
    STEP_OK,
    STEP_ERROR,
    STEP_END
  } step_t;

  typedef struct packed {
    logic              in_frame;
    logic              esc;
    logic              await_kind;
    logic [LEN_W-1:0]  fill;
    logic [BYTE_W-1:0] kind;
  } pstate_t;

  typedef struct packed {
    pstate_t s;
    step_t   r;
    logic    store;
  } presult_t;

  logic [BYTE_W-1:0] start_r;
  logic [BYTE_W-1:0] end_r;
  logic [BYTE_W-1:0] escp_r;
  logic [LEN_W-1:0]  maxlen_r;
  pstate_t           st_r;
  pstate_t           st_nxt;
  logic              bank_r;
  logic [LEN_W-1:0]  lim;
  presult_t          p1;
  presult_t          p2;
  logic              accept;

  function automatic pstate_t clear_fn(input pstate_t s);
    pstate_t c;
    c            = s;
    c.in_frame   = 1'b0;
    c.esc        = 1'b0;
    c.await_kind = 1'b0;
    c.fill       = '0;
    return c;
  endfunction

  function automatic presult_t parse_fn(
    input pstate_t           s,
    input logic [BYTE_W-1:0] x,
    input logic [BYTE_W-1:0] st_c,
    input logic [BYTE_W-1:0] en_c,
    input logic [BYTE_W-1:0] es_c,
    input logic [LEN_W-1:0]  lim_c
  );
    presult_t res;
    res.s     = s;
    res.r     = STEP_OK;
    res.store = 1'b0;
    if (s.in_frame && s.esc) begin
      if (x > es_c || s.fill >= lim_c) begin
        res.r = STEP_ERROR;
      end else begin
        res.store  = 1'b1;
        res.s.fill = s.fill + 1'b1;
        res.s.esc  = 1'b0;
      end
    end else if (s.in_frame && x == es_c) begin
      res.s.esc = 1'b1;
    end else if (!s.in_frame && x == st_c) begin
      res.s.in_frame   = 1'b1;
      res.s.await_kind = 1'b1;
      res.s.fill       = '0;
    end else if (s.in_frame && x == en_c) begin
      res.r = STEP_END;
    end else if (s.in_frame && s.await_kind && x > es_c) begin
      res.s.kind       = x;
      res.s.await_kind = 1'b0;
    end else if (s.in_frame && x > es_c && s.fill < lim_c) begin
      res.store  = 1'b1;
      res.s.fill = s.fill + 1'b1;
    end else begin
      res.r = STEP_ERROR;
    end
    return res;
  endfunction

  assign accept = in_push && !dq_full;
  assign lim    = (maxlen_r > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : maxlen_r;

  // Second pass re-examines the same byte from idle after an error
  assign p1 = parse_fn(st_r, in_rx_data, start_r, end_r, escp_r, lim);
  assign p2 = parse_fn(clear_fn(st_r), in_rx_data, start_r, end_r, escp_r, lim);

  always_comb begin
    st_nxt = p1.s;
    if (p1.r == STEP_ERROR) begin
      st_nxt = p2.s;
      if (p2.r == STEP_ERROR) begin
        st_nxt = clear_fn(p2.s);
      end
    end else if (p1.r == STEP_END) begin
      st_nxt = clear_fn(p1.s);
    end
  end

  assign ram_we      = accept && p1.store && (p1.r == STEP_OK);
  assign ram_waddr   = {bank_r, st_r.fill[IW-1:0]};
  assign ram_wdata   = in_rx_data;
  assign dq_push     = accept && (p1.r == STEP_END);
  assign dq_din.kind = st_r.kind;
  assign dq_din.len  = st_r.fill;
  assign dq_din.bank = bank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= START_RST;
      end_r    <= END_RST;
      escp_r   <= ESCAPE_RST;
      maxlen_r <= MAXLEN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_START:  start_r  <= cfg_wdata;
        CFG_END:    end_r    <= cfg_wdata;
        CFG_ESCAPE: escp_r   <= cfg_wdata;
        CFG_MAXLEN: maxlen_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '0;
      bank_r <= 1'b0;
    end else if (accept) begin
      st_r <= st_nxt;
      // switch to the other bank once a frame is handed off
      if (p1.r == STEP_END) begin
        bank_r <= ~bank_r;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/efd_back.sv -----
`default_nettype none
module efd_back
  import efd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int IW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire desc_t             dq_dout,
  input  wire logic              dq_empty,
  output logic                   dq_pop,
  output logic      [IW:0]       ram_raddr,
  input  wire logic [BYTE_W-1:0] ram_rdata,
  input  wire logic              out_pop,
  output logic                   out_empty,
  output logic      [BYTE_W-1:0] out_frame_kind,
  output logic      [BYTE_W-1:0] out_payload_byte,
  output logic      [POS_W-1:0]  out_byte_position,
  output logic      [LEN_W-1:0]  out_frame_length,
  output logic                   out_last_of_frame
);

  logic [POS_W-1:0]  idx_r;
  logic [LEN_W-1:0]  run_len;
  logic              issue;
  logic              last;
  logic              pv_r;
  logic [BYTE_W-1:0] pkind_r;
  logic [POS_W-1:0]  ppos_r;
  logic [LEN_W-1:0]  plen_r;
  logic              plast_r;
  res_t              ofifo_r [2];
  res_t              push_item;
  res_t              head;
  logic              owp_r;
  logic              orp_r;
  logic [1:0]        ocnt_r;
  logic [1:0]        ocnt_nxt;
  logic              opop;

  // an empty frame still gives one result
  assign run_len   = (dq_dout.len == '0) ? LEN_W'(1) : dq_dout.len;
  assign last      = ((LEN_W'(idx_r) + LEN_W'(1)) == run_len);
  assign issue     = !dq_empty && ((ocnt_r + {1'b0, pv_r}) < 2'd2);
  assign dq_pop    = issue && last;
  assign ram_raddr = {dq_dout.bank, idx_r[IW-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      pv_r  <= 1'b0;
    end else begin
      pv_r <= issue;
      if (issue) begin
        idx_r <= last ? '0 : idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pkind_r <= dq_dout.kind;
      ppos_r  <= idx_r;
      plen_r  <= dq_dout.len;
      plast_r <= last;
    end
  end

  always_comb begin
    push_item.kind = pkind_r;
    push_item.data = (plen_r == '0) ? '0 : ram_rdata;
    push_item.pos  = ppos_r;
    push_item.len  = plen_r;
    push_item.last = plast_r;
  end

  assign opop      = out_pop && !out_empty;
  assign out_empty = (ocnt_r == 2'd0);
  assign head      = ofifo_r[orp_r];

  assign out_frame_kind    = head.kind;
  assign out_payload_byte  = head.data;
  assign out_byte_position = head.pos;
  assign out_frame_length  = head.len;
  assign out_last_of_frame = head.last;

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (pv_r && !opop) begin
      ocnt_nxt = ocnt_r + 2'd1;
    end else if (opop && !pv_r) begin
      ocnt_nxt = ocnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pv_r) begin
      ofifo_r[owp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (pv_r) begin
        owp_r <= ~owp_r;
      end
      if (opop) begin
        orp_r <= ~orp_r;
      end
      ocnt_r <= ocnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/escaped_frame_deframer.sv -----
// Byte-stuffed frame deframer.
// Input: one received byte per item on in_rx_data, taken when in_push is high
// and in_full is low. Frames are START, TYPE, payload, END; payload bytes at or
// below the escape code come behind an escape byte.
// Results: one item per payload byte (or one with frame_length zero for an
// empty frame), shown while out_empty is low and taken with out_pop.
// Configuration: cfg_index/cfg_wdata written when cfg_valid is high; cfg_ready
// is always high. Write only while the block is idle.
// Throughput: the parser takes one byte every cycle while in_full is low.
// Payload sits in a two-bank buffer memory, so one frame can be received while
// the previous one is read out; in_full rises only while both banks hold frames
// not yet read. Readout is paced by the two-entry result queue: a byte is read
// only while queue and read stage hold under two results. After END is taken,
// the descriptor is queued, then the first byte is read and enters the queue.
// Reset: delimiters return to 0/1/2, max_length to 64, buffers and result
// queue empty. A stalled receiver (out_pop low) holds the current result;
// readout stops, and input stalls once both banks are full.
`default_nettype none
module escaped_frame_deframer
  import efd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_wdata,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic [BYTE_W-1:0]    in_rx_data,
  input  wire logic                 out_pop,
  output logic                      out_empty,
  output logic      [BYTE_W-1:0]    out_frame_kind,
  output logic      [BYTE_W-1:0]    out_payload_byte,
  output logic      [POS_W-1:0]     out_byte_position,
  output logic      [LEN_W-1:0]     out_frame_length,
  output logic                      out_last_of_frame
);

  localparam int IW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int DEPTH = 2 * (1 << IW);

  logic              ram_we;
  logic [IW:0]       ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [IW:0]       ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic              dq_push;
  logic              dq_pop;
  logic              dq_empty;
  logic              dq_full;
  desc_t             dq_din;
  desc_t             dq_dout;

  assign cfg_ready = 1'b1;
  assign in_full   = dq_full;

  efd_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .IW          (IW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_push    (in_push),
    .in_rx_data (in_rx_data),
    .dq_full    (dq_full),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .dq_push    (dq_push),
    .dq_din     (dq_din)
  );

  efd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  efd_desc_q u_desc_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (dq_push),
    .din   (dq_din),
    .pop   (dq_pop),
    .dout  (dq_dout),
    .empty (dq_empty),
    .full  (dq_full)
  );

  efd_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .IW          (IW)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .dq_dout           (dq_dout),
    .dq_empty          (dq_empty),
    .dq_pop            (dq_pop),
    .ram_raddr         (ram_raddr),
    .ram_rdata         (ram_rdata),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_frame_kind    (out_frame_kind),
    .out_payload_byte  (out_payload_byte),
    .out_byte_position (out_byte_position),
    .out_frame_length  (out_frame_length),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule
`default_nettype wire

// ----- hdl/efd_checker.sv -----
`default_nettype none
`include "escaped_frame_deframer_assert.svh"
module efd_checker
  import efd_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 cfg_valid,
  input wire logic                 cfg_ready,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [BYTE_W-1:0]    cfg_wdata,
  input wire logic                 in_push,
  input wire logic                 in_full,
  input wire logic [BYTE_W-1:0]    in_rx_data,
  input wire logic                 out_pop,
  input wire logic                 out_empty,
  input wire logic [BYTE_W-1:0]    out_frame_kind,
  input wire logic [BYTE_W-1:0]    out_payload_byte,
  input wire logic [POS_W-1:0]     out_byte_position,
  input wire logic [LEN_W-1:0]     out_frame_length,
  input wire logic                 out_last_of_frame
);

  logic unused_ok;
  assign unused_ok = cfg_valid ^ cfg_ready ^ (^cfg_index) ^ (^cfg_wdata) ^ in_push ^
                     in_full ^ (^in_rx_data);

  // an empty frame gives a single zeroed, last result
  `EFD_ASSERT_NOW(a_empty_frame, !out_empty && out_frame_length == '0,
    out_last_of_frame && out_payload_byte == '0 && out_byte_position == '0,
    "empty frame result malformed")

  `EFD_ASSERT_NOW(a_pos_in_range, !out_empty && out_frame_length != '0,
    LEN_W'(out_byte_position) < out_frame_length, "byte position beyond frame length")

  `EFD_ASSERT_NOW(a_last_mark, !out_empty && out_frame_length != '0,
    out_last_of_frame == ((LEN_W'(out_byte_position) + LEN_W'(1)) == out_frame_length),
    "last mark does not match position")

  `EFD_ASSERT_NEXT(a_hold_result, !out_empty && !out_pop,
    !out_empty && $stable(out_payload_byte) && $stable(out_byte_position) &&
    $stable(out_frame_kind), "stalled result changed")

endmodule

bind escaped_frame_deframer efd_checker u_efd_checker (.*);
`default_nettype wire

// ----- tb/escaped_frame_deframer_tb.sv -----
`timescale 1ns / 100ps
module escaped_frame_deframer_tb;
  import efd_pkg::*;

  localparam int PAYLOAD_MAX     = 64;
  localparam int N_DIR           = 33;
  localparam int N_PHASE         = 6;
  localparam int ITEMS_PER_PHASE = 8;
  localparam int HOLD_PHASE      = 2;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 8;
  localparam int MAX_PRINTS      = 40;

  typedef enum logic [1:0] {PARSE_OK, PARSE_ERR, PARSE_END} parse_t;
  typedef enum logic {ROW_BYTE, ROW_CFG} row_t;

  typedef struct {
    row_t       kind;
    logic [7:0] val;
    cfg_idx_t   idx;
    bit         typed;
    res_t       want;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_wdata;
  logic                 in_push;
  logic                 in_full;
  logic [BYTE_W-1:0]    in_rx_data;
  logic                 out_pop;
  logic                 out_empty;
  logic [BYTE_W-1:0]    out_frame_kind;
  logic [BYTE_W-1:0]    out_payload_byte;
  logic [POS_W-1:0]     out_byte_position;
  logic [LEN_W-1:0]     out_frame_length;
  logic                 out_last_of_frame;

  escaped_frame_deframer #(
    .MAX_PAYLOAD(PAYLOAD_MAX)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_rx_data       (in_rx_data),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_frame_kind   (out_frame_kind),
    .out_payload_byte (out_payload_byte),
    .out_byte_position(out_byte_position),
    .out_frame_length (out_frame_length),
    .out_last_of_frame(out_last_of_frame)
  );

  // Deframer state mirror
  logic [7:0] code_start, code_end, code_esc;
  logic [6:0] len_cap;
  bit         in_frm, esc_pend, want_kind;
  logic [6:0] fill_n;
  logic [7:0] kind_q;
  logic [7:0] pay_mem [PAYLOAD_MAX];
  res_t       step_res[$];
  res_t       frame_out_q[$];

  int tx_idle_pct, rx_idle_pct;
  bit hold_req;
  int hold_left;
  int mismatch_cnt;
  int sent_cnt;

  dir_row_t dir_rows [N_DIR] = '{
    '{ROW_BYTE, 8'h00, CFG_START, 1'b0, '0},
    '{ROW_BYTE, 8'hA5, CFG_START, 1'b0, '0},
    '{ROW_BYTE, 8'h01, CFG_START, 1'b1, res_t'({8'hA5, 8'h00, 6'd0, 7'd0, 1'b1})},
    '{ROW_BYTE, 8'hFF, CFG_START, 1'b0, '0},
    '{ROW_BYTE, 8'h00, CFG_START, 1'b0, '0},
    // escape right after start: payload before the type byte
    '{ROW_BYTE, 8'h02, CFG_START, 1'b0, '0},
    '{ROW_BYTE, 8'h00, CFG_START, 1'b0, '0},
    '{ROW_BYTE, 8'hFF, CFG_START, 1'b0, '0},
    '{ROW_BYTE, 8'hFF, CFG_START, 1'b0, '0},
    '{ROW_BYTE, 8'h02, CFG_START, 1'b0, '0},
    '{ROW_BYTE, 8'h02, CFG_START, 1'b0, '0},
    '{ROW_BYTE, 8'h03, CFG_START, 1'b0, '0},
    '{ROW_BYTE, 8'h01, CFG_START, 1'b0, '0},
    // escaped byte above the escape code
    '{ROW_BYTE, 8'h00, CFG_START, 1'b0, '0},
    '{ROW_BYTE, 8'h02, CFG_START, 1'b0, '0},
    '{ROW_BYTE, 8'h03, CFG_START, 1'b0, '0},
    // start inside a frame reopens it
    '{ROW_BYTE, 8'h00, CFG_START, 1'b0, '0},
    '{ROW_BYTE, 8'h80, CFG_START, 1'b0, '0},
    '{ROW_BYTE, 8'h00, CFG_START, 1'b0, '0},
    '{ROW_BYTE, 8'h01, CFG_START, 1'b1, res_t'({8'h80, 8'h00, 6'd0, 7'd0, 1'b1})},
    '{ROW_CFG,  8'h00, CFG_MAXLEN, 1'b0, '0},
    '{ROW_BYTE, 8'h00, CFG_START, 1'b0, '0},
    '{ROW_BYTE, 8'h44, CFG_START, 1'b0, '0},
    '{ROW_BYTE, 8'h50, CFG_START, 1'b0, '0},
    '{ROW_BYTE, 8'h00, CFG_START, 1'b0, '0},
    '{ROW_BYTE, 8'h01, CFG_START, 1'b1, res_t'({8'h44, 8'h00, 6'd0, 7'd0, 1'b1})},
    '{ROW_CFG,  8'h01, CFG_MAXLEN, 1'b0, '0},
    '{ROW_BYTE, 8'h00, CFG_START, 1'b0, '0},
    '{ROW_BYTE, 8'h61, CFG_START, 1'b0, '0},
    '{ROW_BYTE, 8'h62, CFG_START, 1'b0, '0},
    '{ROW_BYTE, 8'h63, CFG_START, 1'b0, '0},
    '{ROW_BYTE, 8'h00, CFG_START, 1'b0, '0},
    '{ROW_BYTE, 8'h01, CFG_START, 1'b1, res_t'({8'h61, 8'h00, 6'd0, 7'd0, 1'b1})}
  };

  // start, end, escape, max_length per phase; the last phase is drawn at random
  logic [7:0] ph_cfg [N_PHASE][4] = '{
    '{8'h00, 8'h01, 8'h02, 8'd64},
    '{8'h7E, 8'h7F, 8'h7D, 8'd5},
    '{8'hFF, 8'hFE, 8'h00, 8'd64},
    '{8'h00, 8'h00, 8'h01, 8'd0},
    '{8'h10, 8'h20, 8'hFF, 8'd3},
    '{8'h00, 8'h00, 8'h00, 8'd0}
  };

  function automatic int len_limit();
    return (len_cap > PAYLOAD_MAX) ? PAYLOAD_MAX : int'(len_cap);
  endfunction

  function automatic void clear_parse();
    in_frm    = 1'b0;
    esc_pend  = 1'b0;
    want_kind = 1'b0;
    fill_n    = '0;
  endfunction

  function automatic parse_t parse_rx(logic [7:0] x);
    if (in_frm && esc_pend) begin
      if (x > code_esc || fill_n >= len_limit()) return PARSE_ERR;
      pay_mem[fill_n[5:0]] = x;
      fill_n++;
      esc_pend = 1'b0;
      return PARSE_OK;
    end
    if (in_frm && x == code_esc) begin
      esc_pend = 1'b1;
      return PARSE_OK;
    end
    if (!in_frm && x == code_start) begin
      in_frm    = 1'b1;
      want_kind = 1'b1;
      fill_n    = '0;
      return PARSE_OK;
    end
    if (in_frm && x == code_end) return PARSE_END;
    if (in_frm && want_kind && x > code_esc) begin
      kind_q    = x;
      want_kind = 1'b0;
      return PARSE_OK;
    end
    if (in_frm && x > code_esc && fill_n < len_limit()) begin
      pay_mem[fill_n[5:0]] = x;
      fill_n++;
      return PARSE_OK;
    end
    return PARSE_ERR;
  endfunction

  // Fill step_res with the results that byte x releases
  function automatic void decode_rx_byte(logic [7:0] x);
    parse_t r;
    int     n;
    res_t   one;
    step_res.delete();
    r = parse_rx(x);
    if (r == PARSE_ERR) begin
      // reparse the offending byte from idle
      clear_parse();
      r = parse_rx(x);
      if (r == PARSE_ERR) clear_parse();
    end
    if (r != PARSE_END) return;
    n = int'(fill_n);
    if (n == 0) begin
      one.kind = kind_q;
      one.data = 8'h00;
      one.pos  = '0;
      one.len  = '0;
      one.last = 1'b1;
      step_res.push_back(one);
    end else begin
      for (int k = 0; k < n; k++) begin
        one.kind = kind_q;
        one.data = pay_mem[k];
        one.pos  = POS_W'(k);
        one.len  = LEN_W'(n);
        one.last = (k == n - 1);
        step_res.push_back(one);
      end
    end
    clear_parse();
  endfunction

  function automatic void apply_cfg(cfg_idx_t idx, logic [7:0] v);
    case (idx)
      CFG_START:  code_start = v;
      CFG_END:    code_end   = v;
      CFG_ESCAPE: code_esc   = v;
      CFG_MAXLEN: len_cap    = v[6:0];
      default:    ;
    endcase
  endfunction

  task automatic flag_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTS) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_result();
    res_t want;
    if (frame_out_q.size() == 0) begin
      flag_mismatch("result item with nothing pending");
      return;
    end
    want = frame_out_q.pop_front();
    if (out_frame_kind !== want.kind)
      flag_mismatch($sformatf("frame_kind %h, want %h", out_frame_kind, want.kind));
    if (out_payload_byte !== want.data)
      flag_mismatch($sformatf("payload_byte %h, want %h", out_payload_byte, want.data));
    if (out_byte_position !== want.pos)
      flag_mismatch($sformatf("byte_position %0d, want %0d", out_byte_position, want.pos));
    if (out_frame_length !== want.len)
      flag_mismatch($sformatf("frame_length %0d, want %0d", out_frame_length, want.len));
    if (out_last_of_frame !== want.last)
      flag_mismatch($sformatf("last_of_frame %b, want %b", out_last_of_frame, want.last));
  endtask

  task automatic send_byte(logic [7:0] b, bit typed, res_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push    <= 1'b1;
    in_rx_data <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    decode_rx_byte(b);
    if (typed) frame_out_q.push_back(want);
    else foreach (step_res[i]) frame_out_q.push_back(step_res[i]);
    sent_cnt++;
  endtask

  // Hold the sender until every pending result is out and the block settles
  task automatic drain_results();
    in_push <= 1'b0;
    while (frame_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_cfg(idx, v);
  endtask

  task automatic send_frame(bit full_len);
    logic [7:0] fb[$];
    logic [7:0] b;
    int         len;
    fb.push_back(code_start);
    if (code_esc < 8'hFF && $urandom_range(9) != 0) begin
      b = 8'($urandom_range(255, int'(code_esc) + 1));
      if (b != code_end) fb.push_back(b);
    end
    if (full_len) len = PAYLOAD_MAX;
    else if ($urandom_range(9) == 0) len = len_limit() + $urandom_range(1);
    else len = $urandom_range(6);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      while (b > code_esc && b == code_end) b = 8'($urandom_range(255));
      if (b <= code_esc) fb.push_back(code_esc);
      fb.push_back(b);
    end
    fb.push_back(code_end);
    if (!full_len) begin
      // corrupt, truncate or prefix with line noise now and then
      if ($urandom_range(6) == 0) fb[$urandom_range(fb.size() - 1)] = 8'($urandom_range(255));
      if ($urandom_range(9) == 0) void'(fb.pop_back());
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(3, 1)) fb.push_front(8'($urandom_range(255)));
    end
    foreach (fb[i]) send_byte(fb[i], 1'b0, '0);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: check on accept, then pick pop for the next cycle
  initial begin
    out_pop   = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) check_result();
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    int phase_start;
    int budget;
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_rx_data   = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_START;
    cfg_wdata    = '0;
    tx_idle_pct  = 15;
    rx_idle_pct  = 50;
    hold_req     = 1'b0;
    mismatch_cnt = 0;
    sent_cnt     = 0;
    code_start   = START_RST;
    code_end     = END_RST;
    code_esc     = ESCAPE_RST;
    len_cap      = MAXLEN_RST;
    kind_q       = '0;
    clear_parse();
    foreach (pay_mem[i]) pay_mem[i] = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_results();
        write_cfg(dir_rows[i].idx, dir_rows[i].val);
        cfg_valid <= 1'b0;
      end else begin
        send_byte(dir_rows[i].val, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int p = 0; p < N_PHASE; p++) begin
      drain_results();
      if (p == N_PHASE - 1) begin
        ph_cfg[p][0] = 8'($urandom_range(255));
        ph_cfg[p][1] = 8'($urandom_range(255));
        ph_cfg[p][2] = 8'($urandom_range(127));
        ph_cfg[p][3] = 8'($urandom_range(PAYLOAD_MAX));
      end
      for (int r = 0; r < 4; r++) write_cfg(cfg_idx_t'(r), ph_cfg[p][r]);
      cfg_valid <= 1'b0;
      case (p / 2)
        0:       begin tx_idle_pct = 15; rx_idle_pct = 50; end
        1:       begin tx_idle_pct = 50; rx_idle_pct = 15; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      // stall the reader long enough for both buffer banks to fill
      if (p == HOLD_PHASE) hold_req = 1'b1;
      if (p == 0) send_frame(1'b1);
      phase_start = sent_cnt;
      budget = (p == HOLD_PHASE) ? 4 * ITEMS_PER_PHASE : ITEMS_PER_PHASE;
      while (sent_cnt - phase_start < budget) send_frame(1'b0);
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- escaped_frame_deframer.f -----
+incdir+hdl
hdl/efd_pkg.sv
hdl/efd_ram.sv
hdl/efd_desc_q.sv
hdl/efd_front.sv
hdl/efd_back.sv
hdl/escaped_frame_deframer.sv
hdl/efd_checker.sv
tb/escaped_frame_deframer_tb.sv
